### hdl/tisled_pkg.sv
// ----------------------------------------------------------------------------
// tisled_pkg
// Shared constants for the tilt position core with idle sweep.
// ----------------------------------------------------------------------------
package tisled_pkg;

	localparam int STEP_FRACTION_BITS_DEF = 8;
	localparam int MAX_PIXELS             = 255;

	localparam int TILT_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int ELAPSED_W = 17;
	localparam int PIXEL_W   = 8;
	localparam int OUT_POS_W = 16;
	localparam int BASE_W    = 8;

	localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_COUNT   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_NOISE_BAND    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS    = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_STATIC_PERIOD = 2'd3;

	localparam logic [PIXEL_W-1:0] PIXEL_COUNT_RST   = 8'd60;
	localparam logic [CFG_W-1:0]   NOISE_BAND_RST    = 16'd256;
	localparam logic [CFG_W-1:0]   HOLD_TICKS_RST    = 16'd10000;
	localparam logic [CFG_W-1:0]   STATIC_PERIOD_RST = 16'd83;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic ACTION_TICK   = 1'b0;
	localparam logic ACTION_SAMPLE = 1'b1;

endpackage

### hdl/tilt_idle_sweep_led_position_core.sv
// ----------------------------------------------------------------------------
// tilt_idle_sweep_led_position_core
// Turns tilt samples and millisecond ticks into an LED strip position.
//
// The input stream carries one word per tick or tilt sample; s_tuser says
// which. A tick advances the stillness and step counters and gives no output
// word. A sample is offset by half the strip range and clamped, then either
// shown directly or, after the strip has been still for longer than the hold
// time, replaced by a sweep position that bounces end to end one pixel step
// per static period. Each sample gives exactly one output word.
// Words pass an input register and then an output register, and one word is
// accepted every cycle while the output is taken. When the receiver stalls,
// the output register holds and the input register fills, after which
// s_tready drops; ticks keep flowing past a held output. Configuration is
// written through cfg_we, cfg_addr and cfg_data; the user must write it only
// while the stream is idle, as the block does not enforce this. Reset clears
// the position, sweep position and counters and loads the default register values.
// ----------------------------------------------------------------------------
module tilt_idle_sweep_led_position_core
	import tisled_pkg::*;
#(
	parameter int STEP_FRACTION_BITS = STEP_FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // [15:0] tilt
	input  logic                  s_tuser,  // [0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,  // [15:0] shown_position, [23:16] base_index
	output logic [1:0]            m_tuser,  // [0] update_needed, [1] idle_mode
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int POS_W = PIXEL_W + STEP_FRACTION_BITS;
	localparam int SUM_W = ((POS_W > TILT_W) ? POS_W : TILT_W) + 2;

	logic [PIXEL_W-1:0]   pixel_count_q;
	logic [CFG_W-1:0]     noise_band_q;
	logic [CFG_W-1:0]     hold_ticks_q;
	logic [CFG_W-1:0]     static_period_q;

	logic                 valid_s1;
	logic                 action_s1;
	logic [TILT_W-1:0]    tilt_s1;

	logic [POS_W-1:0]     last_pos_q;
	logic                 active_q;
	logic [POS_W-1:0]     sweep_pos_q;
	logic                 rising_q;
	logic [ELAPSED_W-1:0] still_q;
	logic [ELAPSED_W-1:0] step_q;

	logic                 out_free;
	logic                 fire;

	logic [PIXEL_W-1:0]   pixels;
	logic [POS_W-1:0]     full;
	logic [POS_W-1:0]     step_size;
	logic signed [SUM_W-1:0] p_sum;
	logic [POS_W-1:0]     pos;
	logic [POS_W-1:0]     diff;
	logic                 in_band;
	logic [POS_W:0]       rise_sum;
	logic [POS_W:0]       base_sum;

	logic [POS_W-1:0]     last_pos_d;
	logic                 active_d;
	logic [POS_W-1:0]     sweep_pos_d;
	logic                 rising_d;
	logic [ELAPSED_W-1:0] still_d;
	logic [ELAPSED_W-1:0] step_d;
	logic                 update;
	logic [POS_W-1:0]     shown;

	assign out_free = !m_tvalid || m_tready;
	assign fire     = valid_s1 && (action_s1 == ACTION_TICK || out_free);
	assign s_tready = !valid_s1 || fire;

	assign pixels    = (pixel_count_q > PIXEL_W'(MAX_PIXELS)) ? PIXEL_W'(MAX_PIXELS)
	                                                          : pixel_count_q;
	assign full      = {pixels, STEP_FRACTION_BITS'(0)};
	assign step_size = POS_W'(1) << STEP_FRACTION_BITS;
	assign p_sum     = signed'({{(SUM_W-TILT_W){tilt_s1[TILT_W-1]}}, tilt_s1})
	                 + signed'(SUM_W'(full >> 1));

	always_comb begin
		if (p_sum[SUM_W-1]) begin
			pos = '0;
		end else if (SUM_W'(p_sum) > SUM_W'(full)) begin
			pos = full;
		end else begin
			pos = p_sum[POS_W-1:0];
		end
		diff     = (pos > last_pos_q) ? pos - last_pos_q : last_pos_q - pos;
		in_band  = SUM_W'(diff) <= SUM_W'(noise_band_q);
		rise_sum = '0;

		last_pos_d  = last_pos_q;
		active_d    = active_q;
		sweep_pos_d = sweep_pos_q;
		rising_d    = rising_q;
		still_d     = still_q;
		step_d      = step_q;
		update      = 1'b0;

		if (action_s1 == ACTION_TICK) begin
			still_d = (still_q == ELAPSED_MAX) ? still_q : still_q + 1'b1;
			step_d  = (step_q == ELAPSED_MAX) ? step_q : step_q + 1'b1;
		end else begin
			if (in_band) begin
				if (!active_q && still_q > {1'b0, hold_ticks_q}) begin
					active_d    = 1'b1;
					sweep_pos_d = last_pos_q;
				end
			end else begin
				active_d = 1'b0;
				still_d  = '0;
			end
			if (!active_d) begin
				update = 1'b1;
			end else if (step_q > {1'b0, static_period_q}) begin
				step_d = '0;
				update = 1'b1;
			end
			if (!active_d) begin
				last_pos_d = pos;
			end else if (update) begin
				if (rising_q) begin
					rise_sum = {1'b0, sweep_pos_d} + {1'b0, step_size};
					if (rise_sum > {1'b0, full}) begin
						sweep_pos_d = full;
						rising_d    = 1'b0;
					end else begin
						sweep_pos_d = rise_sum[POS_W-1:0];
					end
				end else if (sweep_pos_d < step_size) begin
					sweep_pos_d = '0;
					rising_d    = 1'b1;
				end else begin
					sweep_pos_d = sweep_pos_d - step_size;
				end
			end
		end
		shown    = active_d ? sweep_pos_d : pos;
		base_sum = {1'b0, shown} + ((POS_W+1)'(1) << (STEP_FRACTION_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q   <= PIXEL_COUNT_RST;
			noise_band_q    <= NOISE_BAND_RST;
			hold_ticks_q    <= HOLD_TICKS_RST;
			static_period_q <= STATIC_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PIXEL_COUNT:   pixel_count_q   <= cfg_data[PIXEL_W-1:0];
				REG_NOISE_BAND:    noise_band_q    <= cfg_data;
				REG_HOLD_TICKS:    hold_ticks_q    <= cfg_data;
				REG_STATIC_PERIOD: static_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			tilt_s1   <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q  <= '0;
			active_q    <= 1'b0;
			sweep_pos_q <= '0;
			rising_q    <= 1'b1;
			still_q     <= '0;
			step_q      <= '0;
		end else if (fire) begin
			last_pos_q  <= last_pos_d;
			active_q    <= active_d;
			sweep_pos_q <= sweep_pos_d;
			rising_q    <= rising_d;
			still_q     <= still_d;
			step_q      <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= fire && action_s1 == ACTION_SAMPLE;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && action_s1 == ACTION_SAMPLE) begin
			m_tdata <= {base_sum[STEP_FRACTION_BITS +: BASE_W], OUT_POS_W'(shown)};
			m_tuser <= {active_d, update};
		end
	end

	// Outside idle mode every sample asks for a redraw.
	a_redraw_when_tracking: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> m_tuser[0])
		else $error("sample outside idle mode without redraw");

	// A tick never produces an output word.
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && action_s1 == ACTION_TICK && !m_tvalid) |=> !m_tvalid)
		else $error("tick produced an output word");

	// The step counter only counts up or restarts from zero.
	a_step_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q < $past(step_q)) |-> (step_q == '0))
		else $error("step counter moved backwards");

endmodule
